@@ rtl/sort_then_binary_search_assert.svh @@
// Assertion helpers for the sort and search block.
`ifndef SORT_THEN_BINARY_SEARCH_ASSERT_SVH
`define SORT_THEN_BINARY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define STBS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define STBS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define STBS_ASSERT(label, clk, rst_n, prop, msg)
`define STBS_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/stbs_pkg.sv @@
package stbs_pkg;

    // Result index field width.
    localparam int IDX_W = 6;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic KIND_SORTED = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Cell operation: insert-sort the incoming value, or shift toward the head.
    typedef enum logic {
        MODE_SORT,
        MODE_SHIFT
    } t_cell_mode;

endpackage

@@ rtl/stbs_if.sv @@
interface stbs_in_if import stbs_pkg::*; #(
    parameter int DATA_WIDTH = 32
) ();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [DATA_WIDTH-1:0] value;
    logic                  last;

    modport source (output valid, output cmd, output value, output last, input ready);
    modport sink   (input valid, input cmd, input value, input last, output ready);
endinterface

interface stbs_out_if import stbs_pkg::*; #(
    parameter int DATA_WIDTH = 32
) ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [DATA_WIDTH-1:0] value_res;
    logic [IDX_W-1:0]      index;
    logic                  found;
    logic                  overflow;
    logic                  last_res;

    modport source (
        output valid, output kind, output value_res, output index,
        output found, output overflow, output last_res, input ready
    );
    modport sink (
        input valid, input kind, input value_res, input index,
        input found, input overflow, input last_res, output ready
    );
endinterface

@@ rtl/sort_then_binary_search.sv @@
// Sort-then-search engine.
// i_in carries transactions {cmd, value, last}; o_out carries results
// {kind, value_res, index, found, overflow, last_res}, both valid/ready.
// Loads (cmd = 0) are taken one per cycle while a set is open and stream
// into a chain of DEPTH compare-and-swap cells (insertion sort in flight).
// Loads beyond DEPTH are dropped and flag overflow for that set.
// After the load marked last the chain settles (S_SETTLE), then the
// sorted values shift out of the chain head one per cycle while o_out
// takes them (each also written to a RAM at its index), last_res on the
// final one.
// A search (cmd = 1) does a binary search over the RAM: each probe is an
// address state (RAM read) and a compare state, at most clog2(DEPTH)+1
// probes; a miss ends in the address state, then an answer state follows.
// A search while a set is still open answers not found at once.
// Input ready is high only while the engine is idle. Results sit in an
// output register; a stall on o_out freezes the chain shift / the answer
// until the register frees. Reset empties the chain and clears the count,
// the open-set and overflow flags; RAM contents are only read below count.
`include "sort_then_binary_search_assert.svh"

module sort_then_binary_search import stbs_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stbs_in_if.sink        i_in,
    stbs_out_if.source     o_out
);

    localparam int AW = $clog2(DEPTH);      // RAM address
    localparam int CW = $clog2(DEPTH + 1);  // element count
    localparam int SW = CW + 1;             // signed search bounds
    localparam int TW = $clog2(DEPTH);      // settle timer

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETTLE,
        S_EMIT,
        S_ADDR,
        S_CMP,
        S_ANS
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_set_open, n_set_open;
    logic                  r_ovf, n_ovf;
    logic [TW-1:0]         r_tmr, n_tmr;
    logic [CW-1:0]         r_idx, n_idx;
    logic [SW-1:0]         r_left, n_left;
    logic [SW-1:0]         r_right, n_right;
    logic [SW-1:0]         r_mid, n_mid;
    logic [DATA_WIDTH-1:0] r_target, n_target;
    logic                  r_found, n_found;

    // Output register.
    logic                  r_out_vld, n_out_vld;
    logic                  r_out_kind, n_out_kind;
    logic [DATA_WIDTH-1:0] r_out_val, n_out_val;
    logic [IDX_W-1:0]      r_out_idx, n_out_idx;
    logic                  r_out_found, n_out_found;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;

    logic                  w_in_acc;
    logic                  w_load;
    logic                  w_room;
    logic                  w_ins_vld;
    logic                  w_out_free;
    logic                  w_emit;
    t_cell_mode            w_mode;
    logic [SW-1:0]         w_diff;
    logic [SW-1:0]         w_mid;
    logic [DATA_WIDTH-1:0] w_rdata;

    logic                  w_vld  [DEPTH];
    logic [DATA_WIDTH-1:0] w_val  [DEPTH];
    logic                  w_pvld [DEPTH];
    logic [DATA_WIDTH-1:0] w_pval [DEPTH];

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_load     = w_in_acc && (i_in.cmd == CMD_LOAD);
    // A fresh set always has room; an open one only below DEPTH.
    assign w_room     = !r_set_open || (r_count < CW'(DEPTH));
    assign w_ins_vld  = w_load && w_room;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_emit     = (r_state == S_EMIT) && w_out_free;
    assign w_mode     = w_emit ? MODE_SHIFT : MODE_SORT;

    // Midpoint left + (right - left) / 2, only used while left <= right.
    assign w_diff = r_right - r_left;
    assign w_mid  = r_left + {1'b0, w_diff[SW-1:1]};

    // ---------------------------------------------------------------
    // Sorting chain: new values enter at cell 0, larger ones move right.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                  in_vld;
        logic [DATA_WIDTH-1:0] in_val;
        logic                  nb_vld;
        logic [DATA_WIDTH-1:0] nb_val;

        if (g == 0) begin : g_head
            assign in_vld = w_ins_vld;
            assign in_val = i_in.value;
        end else begin : g_body
            assign in_vld = w_pvld[g-1];
            assign in_val = w_pval[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign nb_vld = 1'b0;
            assign nb_val = '0;
        end else begin : g_link
            assign nb_vld = w_vld[g+1];
            assign nb_val = w_val[g+1];
        end

        stbs_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_mode     (w_mode),
            .i_in_vld   (in_vld),
            .i_in_val   (in_val),
            .i_nb_vld   (nb_vld),
            .i_nb_val   (nb_val),
            .o_vld      (w_vld[g]),
            .o_val      (w_val[g]),
            .o_pass_vld (w_pvld[g]),
            .o_pass_val (w_pval[g])
        );
    end

    // Sorted copy for searching, filled as the chain drains.
    stbs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_emit),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (w_val[0]),
        .i_raddr (w_mid[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_set_open  = r_set_open;
        n_ovf       = r_ovf;
        n_tmr       = r_tmr;
        n_idx       = r_idx;
        n_left      = r_left;
        n_right     = r_right;
        n_mid       = r_mid;
        n_target    = r_target;
        n_found     = r_found;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out_kind  = r_out_kind;
        n_out_val   = r_out_val;
        n_out_idx   = r_out_idx;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (w_load) begin
                    if (!r_set_open) begin
                        n_count    = CW'(1);
                        n_ovf      = 1'b0;
                        n_set_open = 1'b1;
                    end else if (w_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_set_open = 1'b0;
                        n_tmr      = '0;
                        n_state    = S_SETTLE;
                    end
                end else if (w_in_acc) begin
                    n_target = i_in.value;
                    n_found  = 1'b0;
                    n_left   = '0;
                    n_right  = SW'(r_count) - SW'(1);
                    // Open set: nothing sorted to search.
                    n_state  = r_set_open ? S_ANS : S_ADDR;
                end
            end
            S_SETTLE: begin
                n_tmr = r_tmr + TW'(1);
                if (r_tmr == TW'(DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_vld   = 1'b1;
                    n_out_kind  = KIND_SORTED;
                    n_out_val   = w_val[0];
                    n_out_idx   = IDX_W'(r_idx);
                    n_out_found = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_out_last  = (r_idx == r_count - CW'(1));
                    n_idx       = r_idx + CW'(1);
                    if (r_idx == r_count - CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ADDR: begin
                if ($signed(r_left) > $signed(r_right)) begin
                    n_found = 1'b0;
                    n_state = S_ANS;
                end else begin
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_rdata == r_target) begin
                    n_found = 1'b1;
                    n_state = S_ANS;
                end else if ($signed(w_rdata) < $signed(r_target)) begin
                    n_left  = r_mid + SW'(1);
                    n_state = S_ADDR;
                end else begin
                    n_right = r_mid - SW'(1);
                    n_state = S_ADDR;
                end
            end
            S_ANS: begin
                if (w_out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_kind  = KIND_SEARCH;
                    n_out_val   = r_target;
                    n_out_idx   = r_found ? IDX_W'($unsigned(r_mid)) : '0;
                    n_out_found = r_found;
                    n_out_ovf   = r_ovf;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_set_open <= 1'b0;
            r_ovf      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_set_open <= n_set_open;
            r_ovf      <= n_ovf;
            r_out_vld  <= n_out_vld;
        end
        r_tmr       <= n_tmr;
        r_idx       <= n_idx;
        r_left      <= n_left;
        r_right     <= n_right;
        r_mid       <= n_mid;
        r_target    <= n_target;
        r_found     <= n_found;
        r_out_kind  <= n_out_kind;
        r_out_val   <= n_out_val;
        r_out_idx   <= n_out_idx;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.kind      = r_out_kind;
    assign o_out.value_res = r_out_val;
    assign o_out.index     = r_out_idx;
    assign o_out.found     = r_out_found;
    assign o_out.overflow  = r_out_ovf;
    assign o_out.last_res  = r_out_last;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `STBS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count beyond depth")
    `STBS_ASSERT(a_emit_data, i_clk, i_rst_n, w_emit |-> w_vld[0], "chain head empty on emit")
    `STBS_NEVER(a_no_spill, i_clk, i_rst_n, w_pvld[DEPTH-1], "value pushed off chain end")
    // Unsigned compare: a negative mid would read as a large value.
    `STBS_ASSERT(a_probe_range, i_clk, i_rst_n, r_state == S_CMP |-> r_mid < SW'(r_count), "bad probe")

endmodule

@@ rtl/stbs_ram.sv @@
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/stbs_cell.sv @@
module stbs_cell import stbs_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_mode            i_mode,
    input  logic                  i_in_vld,
    input  logic [DATA_WIDTH-1:0] i_in_val,
    input  logic                  i_nb_vld,
    input  logic [DATA_WIDTH-1:0] i_nb_val,
    output logic                  o_vld,
    output logic [DATA_WIDTH-1:0] o_val,
    output logic                  o_pass_vld,
    output logic [DATA_WIDTH-1:0] o_pass_val
);

    logic                  r_vld, n_vld;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic                  r_pass_vld, n_pass_vld;
    logic [DATA_WIDTH-1:0] r_pass_val, n_pass_val;

    // Keep the smaller value, hand the larger one to the right.
    always_comb begin
        n_vld      = r_vld;
        n_val      = r_val;
        n_pass_vld = 1'b0;
        n_pass_val = r_pass_val;
        case (i_mode)
            MODE_SHIFT: begin
                n_vld = i_nb_vld;
                n_val = i_nb_val;
            end
            MODE_SORT: begin
                if (i_in_vld) begin
                    if (!r_vld) begin
                        n_vld = 1'b1;
                        n_val = i_in_val;
                    end else if ($signed(i_in_val) < $signed(r_val)) begin
                        n_val      = i_in_val;
                        n_pass_vld = 1'b1;
                        n_pass_val = r_val;
                    end else begin
                        n_pass_vld = 1'b1;
                        n_pass_val = i_in_val;
                    end
                end
            end
            default: begin
                n_vld = r_vld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_pass_vld <= 1'b0;
        end else begin
            r_vld      <= n_vld;
            r_pass_vld <= n_pass_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_pass_val <= n_pass_val;
    end

    assign o_vld      = r_vld;
    assign o_val      = r_val;
    assign o_pass_vld = r_pass_vld;
    assign o_pass_val = r_pass_val;

endmodule

@@ test/tb_sort_then_binary_search.sv @@
module tb_sort_then_binary_search;
    import stbs_pkg::*;

    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int CLK_PERIOD  = 20;
    localparam int RESET_CYCLES = 10;
    // Random part length, counted in input transactions after the overflow set and its searches.
    localparam int RANDOM_ITEMS = 36;
    // Long receiver hold-off used to back the engine up into its input.
    localparam int HOLD_CYCLES = 400;
    // Hard stop for the whole run, in clock cycles.
    localparam int WATCHDOG_CYCLES = 200000;

    // One result as seen on o_out.
    typedef struct packed {
        logic                  kind;
        logic [DATA_WIDTH-1:0] value_res;
        logic [IDX_W-1:0]      index;
        logic                  found;
        logic                  overflow;
        logic                  last_res;
    } t_stbs_result;

    // ------------------------------------------------------------------
    // Shadow of the sort/search engine plus the queue of results it owes.
    // Fed with every accepted input transaction, drained by every result.
    // ------------------------------------------------------------------
    class sort_search_model;
        logic signed [DATA_WIDTH-1:0] shadow_vals[DEPTH];
        int                           shadow_count;
        bit                           shadow_open;
        bit                           shadow_overflow;
        t_stbs_result                 results_due[$];

        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned sets_done;
        int unsigned overflow_sets;
        int unsigned search_hits;
        int unsigned search_misses;

        function new();
            shadow_count    = 0;
            shadow_open     = 1'b0;
            shadow_overflow = 1'b0;
            mismatches      = 0;
            results_seen    = 0;
            sets_done       = 0;
            overflow_sets   = 0;
            search_hits     = 0;
            search_misses   = 0;
        endfunction

        // Binary search over the sorted set; mid = lo + (hi - lo) / 2.
        function void answer_search(logic [DATA_WIDTH-1:0] target);
            t_stbs_result r;
            int lo, hi, mid, pos;
            bit hit;
            hit = 1'b0;
            pos = 0;
            // An open set is never searched: the answer is "not found".
            if (!shadow_open) begin
                lo = 0;
                hi = shadow_count - 1;
                while (lo <= hi && !hit) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_vals[mid] == $signed(target)) begin
                        hit = 1'b1;
                        pos = mid;
                    end else if (shadow_vals[mid] < $signed(target)) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            if (hit) search_hits++;
            else search_misses++;
            r.kind      = KIND_SEARCH;
            r.value_res = target;
            r.index     = IDX_W'(pos);
            r.found     = hit;
            r.overflow  = shadow_overflow;
            r.last_res  = 1'b1;
            results_due.push_back(r);
        endfunction

        // Closing load: insertion sort, then one result per stored value.
        function void emit_sorted();
            t_stbs_result r;
            logic signed [DATA_WIDTH-1:0] cur;
            int j;
            for (int i = 1; i < shadow_count; i++) begin
                cur = shadow_vals[i];
                j = i;
                while (j > 0 && shadow_vals[j-1] > cur) begin
                    shadow_vals[j] = shadow_vals[j-1];
                    j--;
                end
                shadow_vals[j] = cur;
            end
            for (int i = 0; i < shadow_count; i++) begin
                r.kind      = KIND_SORTED;
                r.value_res = shadow_vals[i];
                r.index     = IDX_W'(i);
                r.found     = 1'b0;
                r.overflow  = shadow_overflow;
                r.last_res  = (i == shadow_count - 1);
                results_due.push_back(r);
            end
            sets_done++;
            if (shadow_overflow) overflow_sets++;
        endfunction

        function void take_transaction(logic cmd, logic [DATA_WIDTH-1:0] value, logic last);
            if (cmd == CMD_SEARCH) begin
                answer_search(value);
                return;
            end
            // First load after a finished set starts a fresh one.
            if (!shadow_open) begin
                shadow_count    = 0;
                shadow_overflow = 1'b0;
                shadow_open     = 1'b1;
            end
            if (shadow_count < DEPTH) begin
                shadow_vals[shadow_count] = value;
                shadow_count++;
            end else begin
                shadow_overflow = 1'b1;
            end
            if (last) begin
                shadow_open = 1'b0;
                emit_sorted();
            end
        endfunction

        function bit field_ok(string name, logic [DATA_WIDTH-1:0] want,
                              logic [DATA_WIDTH-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(t_stbs_result got);
            t_stbs_result want;
            bit ok;
            results_seen++;
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, actual %p",
                         $time, got);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            ok = 1'b1;
            ok &= field_ok("kind",      want.kind,      got.kind);
            ok &= field_ok("value_res", want.value_res, got.value_res);
            ok &= field_ok("index",     want.index,     got.index);
            ok &= field_ok("found",     want.found,     got.found);
            ok &= field_ok("overflow",  want.overflow,  got.overflow);
            ok &= field_ok("last_res",  want.last_res,  got.last_res);
            if (!ok) mismatches++;
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    stbs_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_if  ();
    stbs_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_if ();

    sort_then_binary_search #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sort_search_model model = new();

    // Idle rates in percent; changed only by the stimulus process.
    int send_idle_pct = 23;
    int recv_idle_pct = 64;

    // Hold-off requests: stimulus bumps hold_req_cnt, receiver serves it.
    int hold_req_cnt  = 0;
    int hold_done_cnt = 0;
    int hold_left     = 0;

    int items_sent = 0;
    // Values of the most recent set, so searches can aim at real entries.
    logic [DATA_WIDTH-1:0] loaded_vals[$];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: random back-pressure, or a long solid stall on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_req_cnt != hold_done_cnt) begin
            hold_done_cnt <= hold_req_cnt;
            hold_left     <= HOLD_CYCLES;
            out_if.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Input monitor: every accepted transaction goes to the shadow model.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            model.take_transaction(in_if.cmd, in_if.value, in_if.last);
    end

    // Output monitor: every accepted result is checked against the oldest one owed.
    always @(posedge i_clk) begin
        t_stbs_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.kind      = out_if.kind;
            got.value_res = out_if.value_res;
            got.index     = out_if.index;
            got.found     = out_if.found;
            got.overflow  = out_if.overflow;
            got.last_res  = out_if.last_res;
            model.check_result(got);
        end
    end

    // Offer one transaction, with random idle cycles in front of it,
    // and return at the edge where it is taken.
    task automatic send_item(logic cmd, logic [DATA_WIDTH-1:0] value, logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.cmd   <= cmd;
        in_if.value <= value;
        in_if.last  <= last;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    // Mix of full-range values, a narrow band that forces duplicates, and the extremes.
    function automatic logic [DATA_WIDTH-1:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom_range(15) - 8;
            1: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Search for an entry of the last set most of the time, else anything.
    task automatic send_search();
        logic [DATA_WIDTH-1:0] target;
        if (loaded_vals.size() > 0 && $urandom_range(2) != 0)
            target = loaded_vals[$urandom_range(loaded_vals.size() - 1)];
        else
            target = rand_value();
        // last is ignored on searches but toggled anyway
        send_item(CMD_SEARCH, target, $urandom_range(1));
    endtask

    // A complete load set; optionally a search slips in while it is open.
    task automatic send_set(int n, bit cut_in);
        logic [DATA_WIDTH-1:0] v;
        loaded_vals.delete();
        for (int i = 0; i < n; i++) begin
            if (cut_in && n > 1 && i == n / 2)
                send_search();
            v = rand_value();
            loaded_vals.push_back(v);
            send_item(CMD_LOAD, v, i == n - 1);
        end
    endtask

    // Sender pause: nothing new goes in until every owed result is out.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        // One edge first, so the monitors have logged the last transaction.
        @(posedge i_clk);
        while (model.results_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        int phase;
        int base;

        in_if.valid  = 1'b0;
        in_if.cmd    = CMD_LOAD;
        in_if.value  = '0;
        in_if.last   = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed part ----------------
        // Search before any set exists: not found.
        send_item(CMD_SEARCH, 32'h0, 1'b0);
        // Extremes and a duplicate in one set.
        send_item(CMD_LOAD, 32'h7FFF_FFFF, 1'b0);
        send_item(CMD_LOAD, 32'h8000_0000, 1'b0);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
        send_item(CMD_LOAD, 32'h0000_0000, 1'b0);
        send_item(CMD_LOAD, 32'h0000_0001, 1'b0);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_SEARCH, 32'h8000_0000, 1'b0);   // lowest entry
        send_item(CMD_SEARCH, 32'h7FFF_FFFF, 1'b0);   // highest entry
        send_item(CMD_SEARCH, 32'hFFFF_FFFF, 1'b1);   // duplicated entry
        send_item(CMD_SEARCH, 32'h0000_0002, 1'b0);   // absent
        // Search while a set is open must miss and leave the set alone.
        send_item(CMD_LOAD, 32'd5, 1'b0);
        send_item(CMD_SEARCH, 32'd5, 1'b0);
        send_item(CMD_LOAD, -32'sd5, 1'b1);
        send_item(CMD_SEARCH, 32'd5, 1'b0);
        // Single-entry set.
        send_item(CMD_LOAD, 32'd42, 1'b1);
        send_item(CMD_SEARCH, 32'd42, 1'b0);
        send_item(CMD_SEARCH, 32'd41, 1'b0);
        // All-equal set: the hit is wherever the first probe lands.
        send_item(CMD_LOAD, 32'd7, 1'b0);
        send_item(CMD_LOAD, 32'd7, 1'b0);
        send_item(CMD_LOAD, 32'd7, 1'b0);
        send_item(CMD_LOAD, 32'd7, 1'b1);
        send_item(CMD_SEARCH, 32'd7, 1'b0);
        wait_drained();

        // ---------------- random part ----------------
        // Overflow set first, with the receiver frozen for a long stretch so
        // the chain backs up and the input stalls while the sender keeps offering.
        hold_req_cnt <= hold_req_cnt + 1;
        send_set(DEPTH + 1 + $urandom_range(3), 1'b0);
        send_search();
        send_search();

        base  = items_sent;
        phase = 0;
        while (items_sent < base + RANDOM_ITEMS) begin
            // Idle-profile switches happen with the engine drained.
            if (phase == 0 && items_sent >= base + RANDOM_ITEMS / 3) begin
                wait_drained();
                send_idle_pct <= 64;
                recv_idle_pct <= 23;
                phase = 1;
            end else if (phase == 1 && items_sent >= base + (2 * RANDOM_ITEMS) / 3) begin
                wait_drained();
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
                phase = 2;
            end
            pick = $urandom_range(99);
            if (pick < 65)
                send_set(($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8),
                         1'b0);
            else if (pick < 80)
                send_set($urandom_range(2, 8), 1'b1);
            else
                send_search();
            repeat ($urandom_range(3)) send_search();
        end
        wait_drained();

        // Allow for a stray late result before judging.
        repeat (3 * DEPTH) @(posedge i_clk);

        $display("Covered %0d sorted sets (%0d overflowed), %0d searches (%0d hits, %0d misses).",
                 model.sets_done, model.overflow_sets,
                 model.search_hits + model.search_misses,
                 model.search_hits, model.search_misses);
        $display("Checked %0d results from %0d input transactions.",
                 model.results_seen, items_sent);
        if (model.mismatches == 0 && model.results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("%0t: timeout, %0d results still pending", $time, model.results_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
